FILE: rtl/srs_pkg.sv
// ----------------------------------------------------------------------------
// srs_pkg - shared types and constants of the slice retransmit scheduler
// request codes, field widths and parameter defaults
// ----------------------------------------------------------------------------
package srs_pkg;

  // parameter defaults
  localparam int SLICE_BYTES_DEF      = 1024;
  localparam int SLICES_PER_BLOCK_DEF = 64;

  // fixed field widths
  localparam int REQ_W    = 2;
  localparam int BLOCK_W  = 32;
  localparam int MASK_W   = 64;
  localparam int SLICE_W  = 32;
  localparam int FILE_W   = 40;
  localparam int LEN_W    = 11;
  localparam int COUNT_W  = 32;

  // request kinds
  typedef enum logic [REQ_W-1:0] {
    REQ_BLOCK = 2'd0,
    REQ_PULL  = 2'd1,
    REQ_ACK   = 2'd2,
    REQ_LOSS  = 2'd3
  } req_type_t;

endpackage

FILE: rtl/srs_lsb_pick.sv
// ----------------------------------------------------------------------------
// srs_lsb_pick - lowest set bit picker
// isolates the lowest set bit of a bitmap and encodes its position
// ----------------------------------------------------------------------------
module srs_lsb_pick #(
  parameter int SLICES_PER_BLOCK = srs_pkg::SLICES_PER_BLOCK_DEF,
  parameter int IDX_W            = $clog2(SLICES_PER_BLOCK)
) (
  input  logic [SLICES_PER_BLOCK-1:0] bits,
  output logic [SLICES_PER_BLOCK-1:0] onehot,
  output logic [IDX_W-1:0]            pos
);

  // two's complement trick keeps only the lowest one
  assign onehot = bits & (~bits + {{(SLICES_PER_BLOCK-1){1'b0}}, 1'b1});

  always_comb begin
    pos = '0;
    for (int i = 0; i < SLICES_PER_BLOCK; i++) begin
      if (onehot[i]) begin
        pos = pos | IDX_W'(i);
      end
    end
  end

endmodule

FILE: rtl/slice_retransmit_scheduler.sv
// ----------------------------------------------------------------------------
// slice_retransmit_scheduler - sender side slice scheduler
// selective repeat bitmaps over the slices of the current block
// ----------------------------------------------------------------------------
//
//  channel | handshake                     | payload
//  --------+-------------------------------+-------------------------------------
//  in      | in_valid / in_stall           | req_type, block_index, have_mask,
//          |                               | slice_number
//  out     | out_valid / out_stall         | accepted, issued_slice, byte_offset,
//          |                               | slice_length, pull/ack/loss counts
//  cfg     | cfg_wr_en                     | cfg_wr_data (file_size)
//
//  one item per cycle sustained while out_stall is low; each item passes the
//  input register, the bitmap update and slice pick, then the result register
//  reset (rst_n low, synchronous) clears bitmaps, block base, counters and
//  file_size, and empties both pipeline registers
//  out_stall holds the result register; the input register then waits and
//  in_stall rises, so no item is lost or repeated
// ----------------------------------------------------------------------------
module slice_retransmit_scheduler #(
  parameter int SLICE_BYTES      = srs_pkg::SLICE_BYTES_DEF,
  parameter int SLICES_PER_BLOCK = srs_pkg::SLICES_PER_BLOCK_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,

  // configuration
  input  logic                          cfg_wr_en,
  input  logic [srs_pkg::FILE_W-1:0]    cfg_wr_data,

  // request channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [srs_pkg::REQ_W-1:0]     in_req_type,
  input  logic [srs_pkg::BLOCK_W-1:0]   in_block_index,
  input  logic [srs_pkg::MASK_W-1:0]    in_have_mask,
  input  logic [srs_pkg::SLICE_W-1:0]   in_slice_number,

  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_accepted,
  output logic [srs_pkg::SLICE_W-1:0]   out_issued_slice,
  output logic [srs_pkg::FILE_W-1:0]    out_byte_offset,
  output logic [srs_pkg::LEN_W-1:0]     out_slice_length,
  output logic [srs_pkg::COUNT_W-1:0]   out_pull_count,
  output logic [srs_pkg::COUNT_W-1:0]   out_ack_count,
  output logic [srs_pkg::COUNT_W-1:0]   out_loss_count
);

  localparam int SPB       = SLICES_PER_BLOCK;
  localparam int IDX_W     = $clog2(SPB);
  localparam int BLK_BYTES = SPB * SLICE_BYTES;
  // global slice index of a block base and byte offset of a block
  localparam int BASE_W    = srs_pkg::BLOCK_W + $clog2(SPB);
  localparam int BOFF_W    = srs_pkg::BLOCK_W + $clog2(BLK_BYTES);
  // common width for byte compares against file_size
  localparam int CW        = ((BOFF_W > srs_pkg::FILE_W) ? BOFF_W : srs_pkg::FILE_W) + 1;
  localparam int DW        = BASE_W + 1;

  // --------------------------------------------------------------------------
  // state
  // --------------------------------------------------------------------------
  logic [srs_pkg::FILE_W-1:0]  file_size_r;
  logic [SPB-1:0]              to_send_r,  to_send_nxt;
  logic [SPB-1:0]              awaiting_r, awaiting_nxt;
  // the current block is kept as its slice base and byte offset
  logic [BASE_W-1:0]           base_r,     base_nxt;
  logic [BOFF_W-1:0]           boff_r,     boff_nxt;
  logic [srs_pkg::COUNT_W-1:0] pulls_r,    pulls_nxt;
  logic [srs_pkg::COUNT_W-1:0] acks_r,     acks_nxt;
  logic [srs_pkg::COUNT_W-1:0] losses_r,   losses_nxt;

  // input register
  logic                        s1_valid_r;
  srs_pkg::req_type_t          s1_req_r;
  logic [srs_pkg::BLOCK_W-1:0] s1_block_r;
  logic [SPB-1:0]              s1_have_r;
  logic [srs_pkg::SLICE_W-1:0] s1_slice_r;

  // result register
  logic                        out_valid_r;
  logic                        acc_r,    acc_nxt;
  logic [srs_pkg::SLICE_W-1:0] issued_r, issued_nxt;
  logic [srs_pkg::FILE_W-1:0]  offs_r,   offs_nxt;
  logic [srs_pkg::LEN_W-1:0]   len_r,    len_nxt;

  // --------------------------------------------------------------------------
  // handshake
  // --------------------------------------------------------------------------
  logic in_take;
  logic move;

  // the held item moves on when the result register is empty or draining
  assign move     = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !move;
  assign in_take  = in_valid && !in_stall;

  // --------------------------------------------------------------------------
  // lowest to-send slice
  // --------------------------------------------------------------------------
  logic [SPB-1:0]   pick_onehot;
  logic [IDX_W-1:0] pick_pos;

  srs_lsb_pick #(
    .SLICES_PER_BLOCK (SPB),
    .IDX_W            (IDX_W)
  ) u_pick (
    .bits   (to_send_r),
    .onehot (pick_onehot),
    .pos    (pick_pos)
  );

  // --------------------------------------------------------------------------
  // block request terms
  // --------------------------------------------------------------------------
  logic [BOFF_W-1:0] req_boff;
  logic [BASE_W-1:0] req_base;
  logic [CW-1:0]     fsz_ext;
  logic              req_past;
  logic [CW-1:0]     req_rem;
  logic [SPB-1:0]    req_in_file;
  logic [SPB-1:0]    req_to_send;

  assign req_boff = BOFF_W'(s1_block_r) * BOFF_W'(BLK_BYTES);
  assign req_base = BASE_W'(s1_block_r) * BASE_W'(SPB);
  assign fsz_ext  = CW'(file_size_r);
  // block starts at or past end of file
  assign req_past = CW'(req_boff) >= fsz_ext;
  assign req_rem  = fsz_ext - CW'(req_boff);

  // slice i lies in the file when its start is below the end
  always_comb begin
    for (int i = 0; i < SPB; i++) begin
      req_in_file[i] = req_rem > CW'(i * SLICE_BYTES);
    end
  end

  assign req_to_send = to_send_r | (~s1_have_r & req_in_file);

  // --------------------------------------------------------------------------
  // pull terms
  // --------------------------------------------------------------------------
  logic [BASE_W-1:0] pull_slice;
  logic [CW-1:0]     pull_offs;
  logic [CW-1:0]     pull_left;
  logic [CW-1:0]     pull_len;

  assign pull_slice = base_r + BASE_W'(pick_pos);
  assign pull_offs  = CW'(boff_r) + CW'(pick_pos) * CW'(SLICE_BYTES);
  assign pull_left  = fsz_ext - pull_offs;

  always_comb begin
    if (pull_offs >= fsz_ext) begin
      pull_len = '0;               // slice past end of file
    end else if (pull_left > CW'(SLICE_BYTES)) begin
      pull_len = CW'(SLICE_BYTES);
    end else begin
      pull_len = pull_left;        // short last slice
    end
  end

  // --------------------------------------------------------------------------
  // ack and loss terms
  // --------------------------------------------------------------------------
  logic [DW-1:0]  sn_delta;
  logic           sn_current;
  logic [SPB-1:0] sn_bit;

  assign sn_delta   = DW'(s1_slice_r) - DW'(base_r);
  // below the block base the subtraction borrows into the top bit
  assign sn_current = DW'(s1_slice_r) >= DW'(base_r);
  // beyond the block the named slice has no bit
  assign sn_bit     = (sn_delta < DW'(SPB))
                      ? ({{(SPB-1){1'b0}}, 1'b1} << sn_delta[IDX_W-1:0])
                      : '0;

  // --------------------------------------------------------------------------
  // next state and result
  // --------------------------------------------------------------------------
  always_comb begin
    to_send_nxt  = to_send_r;
    awaiting_nxt = awaiting_r;
    base_nxt     = base_r;
    boff_nxt     = boff_r;
    pulls_nxt    = pulls_r;
    acks_nxt     = acks_r;
    losses_nxt   = losses_r;
    acc_nxt      = 1'b0;
    issued_nxt   = '0;
    offs_nxt     = '0;
    len_nxt      = '0;

    unique case (s1_req_r)
      srs_pkg::REQ_BLOCK: begin
        if (!req_past) begin
          to_send_nxt = req_to_send;
          // an empty map rejects the request but keeps the current block
          if (req_to_send != '0) begin
            base_nxt = req_base;
            boff_nxt = req_boff;
            acc_nxt  = 1'b1;
          end
        end
      end
      srs_pkg::REQ_PULL: begin
        if (to_send_r != '0) begin
          to_send_nxt  = to_send_r & ~pick_onehot;
          awaiting_nxt = awaiting_r | pick_onehot;
          pulls_nxt    = pulls_r + srs_pkg::COUNT_W'(1);
          acc_nxt      = 1'b1;
          issued_nxt   = pull_slice[srs_pkg::SLICE_W-1:0];
          offs_nxt     = pull_offs[srs_pkg::FILE_W-1:0];
          len_nxt      = pull_len[srs_pkg::LEN_W-1:0];
        end
      end
      srs_pkg::REQ_ACK: begin
        if (sn_current) begin
          acks_nxt     = acks_r + srs_pkg::COUNT_W'(1);
          awaiting_nxt = awaiting_r & ~sn_bit;
          acc_nxt      = 1'b1;
        end
      end
      srs_pkg::REQ_LOSS: begin
        if (sn_current) begin
          losses_nxt = losses_r + srs_pkg::COUNT_W'(1);
          acc_nxt    = 1'b1;
          // only an awaiting slice goes back to the to-send map
          if ((awaiting_r & sn_bit) != '0) begin
            awaiting_nxt = awaiting_r & ~sn_bit;
            to_send_nxt  = to_send_r | sn_bit;
          end
        end
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      file_size_r <= '0;
    end else if (cfg_wr_en) begin
      file_size_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      to_send_r  <= '0;
      awaiting_r <= '0;
      base_r     <= '0;
      boff_r     <= '0;
      pulls_r    <= '0;
      acks_r     <= '0;
      losses_r   <= '0;
    end else if (move) begin
      to_send_r  <= to_send_nxt;
      awaiting_r <= awaiting_nxt;
      base_r     <= base_nxt;
      boff_r     <= boff_nxt;
      pulls_r    <= pulls_nxt;
      acks_r     <= acks_nxt;
      losses_r   <= losses_nxt;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (move) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_req_r   <= srs_pkg::req_type_t'(in_req_type);
      s1_block_r <= in_block_index;
      s1_have_r  <= in_have_mask[SPB-1:0];
      s1_slice_r <= in_slice_number;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (move) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      acc_r    <= acc_nxt;
      issued_r <= issued_nxt;
      offs_r   <= offs_nxt;
      len_r    <= len_nxt;
    end
  end

  // counters are shown as they stand after the item
  assign out_valid        = out_valid_r;
  assign out_accepted     = acc_r;
  assign out_issued_slice = issued_r;
  assign out_byte_offset  = offs_r;
  assign out_slice_length = len_r;
  assign out_pull_count   = pulls_r;
  assign out_ack_count    = acks_r;
  assign out_loss_count   = losses_r;

endmodule

FILE: test/slice_schedule_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slice_schedule_checker - result checker for the slice retransmit scheduler
// predicts each result from the accepted requests and compares it field by field
// ----------------------------------------------------------------------------
module slice_schedule_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [srs_pkg::FILE_W-1:0]    cfg_wr_data,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [srs_pkg::REQ_W-1:0]     in_req_type,
  input  logic [srs_pkg::BLOCK_W-1:0]   in_block_index,
  input  logic [srs_pkg::MASK_W-1:0]    in_have_mask,
  input  logic [srs_pkg::SLICE_W-1:0]   in_slice_number,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic                          out_accepted,
  input  logic [srs_pkg::SLICE_W-1:0]   out_issued_slice,
  input  logic [srs_pkg::FILE_W-1:0]    out_byte_offset,
  input  logic [srs_pkg::LEN_W-1:0]     out_slice_length,
  input  logic [srs_pkg::COUNT_W-1:0]   out_pull_count,
  input  logic [srs_pkg::COUNT_W-1:0]   out_ack_count,
  input  logic [srs_pkg::COUNT_W-1:0]   out_loss_count,
  output int                            fail_count,
  output int                            pending,
  output int                            checked
);
  import srs_pkg::*;

  localparam logic [63:0] SLICE_SZ     = 64'(SLICE_BYTES_DEF);
  localparam logic [63:0] BLOCK_SLICES = 64'(SLICES_PER_BLOCK_DEF);
  localparam logic [63:0] BLOCK_SZ     = SLICE_SZ * BLOCK_SLICES;

  typedef struct packed {
    logic                 accepted;
    logic [SLICE_W-1:0]   issued_slice;
    logic [FILE_W-1:0]    byte_offset;
    logic [LEN_W-1:0]     slice_length;
    logic [COUNT_W-1:0]   pull_count;
    logic [COUNT_W-1:0]   ack_count;
    logic [COUNT_W-1:0]   loss_count;
  } slice_reply_t;

  // scheduler state as predicted
  logic [MASK_W-1:0]  to_send_map;
  logic [MASK_W-1:0]  awaiting_map;
  logic [BLOCK_W-1:0] cur_block;
  logic [COUNT_W-1:0] pulls;
  logic [COUNT_W-1:0] acks;
  logic [COUNT_W-1:0] losses;
  logic [FILE_W-1:0]  file_bytes;

  slice_reply_t replies_due[$];
  int mismatches = 0;
  int outstanding = 0;
  int compared = 0;

  assign fail_count = mismatches;
  assign pending    = outstanding;
  assign checked    = compared;

  function automatic slice_reply_t predict_schedule(input req_type_t kind,
                                                    input logic [BLOCK_W-1:0] blk,
                                                    input logic [MASK_W-1:0] have,
                                                    input logic [SLICE_W-1:0] sn);
    logic [63:0] base, nblocks, nslices, first, count, span, g, o, len, d, sel;
    int pos;
    slice_reply_t r;
    r = '0;
    pos = 0;
    base = {32'b0, cur_block} * BLOCK_SLICES;
    case (kind)
      REQ_BLOCK: begin
        nblocks = ({24'b0, file_bytes} + BLOCK_SZ - 64'd1) / BLOCK_SZ;
        nslices = ({24'b0, file_bytes} + SLICE_SZ - 64'd1) / SLICE_SZ;
        if ({32'b0, blk} < nblocks) begin
          first = {32'b0, blk} * BLOCK_SLICES;
          count = nslices - first;
          if (count > BLOCK_SLICES) count = BLOCK_SLICES;
          span = (count >= 64) ? '1 : ((64'd1 << count) - 64'd1);
          // old bits stay and become slices of the new block
          to_send_map |= ~have & span;
          if (to_send_map != '0) begin
            cur_block = blk;
            r.accepted = 1'b1;
          end
        end
      end
      REQ_PULL: begin
        if (to_send_map != '0) begin
          for (int i = 63; i >= 0; i--) if (to_send_map[i]) pos = i;
          g = base + 64'(pos);
          o = g * SLICE_SZ;
          len = 64'd0;
          if (o < {24'b0, file_bytes}) begin
            len = {24'b0, file_bytes} - o;
            if (len > SLICE_SZ) len = SLICE_SZ;
          end
          r.issued_slice = g[SLICE_W-1:0];
          r.byte_offset  = o[FILE_W-1:0];
          r.slice_length = len[LEN_W-1:0];
          to_send_map[pos]  = 1'b0;
          awaiting_map[pos] = 1'b1;
          pulls++;
          r.accepted = 1'b1;
        end
      end
      default: begin
        // acks and losses under the block base are dropped
        if ({32'b0, sn} >= base) begin
          d = {32'b0, sn} - base;
          sel = (d < BLOCK_SLICES) ? (64'd1 << d) : 64'd0;
          r.accepted = 1'b1;
          if (kind == REQ_ACK) begin
            acks++;
            awaiting_map &= ~sel;
          end else begin
            losses++;
            if ((awaiting_map & sel) != '0) begin
              awaiting_map &= ~sel;
              to_send_map  |= sel;
            end
          end
        end
      end
    endcase
    r.pull_count = pulls;
    r.ack_count  = acks;
    r.loss_count = losses;
    return r;
  endfunction

  task automatic check_field(input string field, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    slice_reply_t want;
    if (!rst_n) begin
      to_send_map  = '0;
      awaiting_map = '0;
      cur_block    = '0;
      pulls        = '0;
      acks         = '0;
      losses       = '0;
      file_bytes   = '0;
      replies_due.delete();
      outstanding  = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (replies_due.size() == 0) begin
          $error("result with no request waiting for it");
          mismatches++;
        end else begin
          want = replies_due.pop_front();
          outstanding--;
          compared++;
          check_field("accepted", 64'(want.accepted), 64'(out_accepted));
          check_field("issued_slice", 64'(want.issued_slice), 64'(out_issued_slice));
          check_field("byte_offset", 64'(want.byte_offset), 64'(out_byte_offset));
          check_field("slice_length", 64'(want.slice_length), 64'(out_slice_length));
          check_field("pull_count", 64'(want.pull_count), 64'(out_pull_count));
          check_field("ack_count", 64'(want.ack_count), 64'(out_ack_count));
          check_field("loss_count", 64'(want.loss_count), 64'(out_loss_count));
        end
      end
      if (in_valid && !in_stall) begin
        replies_due.push_back(predict_schedule(req_type_t'(in_req_type), in_block_index,
                                               in_have_mask, in_slice_number));
        outstanding++;
      end
      if (cfg_wr_en) file_bytes = cfg_wr_data;
    end
  end

endmodule

FILE: test/tb_slice_retransmit_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_slice_retransmit_scheduler - testbench of the slice retransmit scheduler
// directed block, pull, ack and loss requests, then random request bursts over
// several file sizes and idle patterns; a checker module predicts every result
// ----------------------------------------------------------------------------
module tb_slice_retransmit_scheduler;
  import srs_pkg::*;

  typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  localparam int PHASES     = 10;
  localparam int PHASE_REQS = 100;
  localparam int HOLD_LEN   = 200;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_wr_en;
  logic [FILE_W-1:0]    cfg_wr_data;
  logic                 in_valid;
  logic                 in_stall;
  logic [REQ_W-1:0]     in_req_type;
  logic [BLOCK_W-1:0]   in_block_index;
  logic [MASK_W-1:0]    in_have_mask;
  logic [SLICE_W-1:0]   in_slice_number;
  logic                 out_valid;
  logic                 out_stall;
  logic                 out_accepted;
  logic [SLICE_W-1:0]   out_issued_slice;
  logic [FILE_W-1:0]    out_byte_offset;
  logic [LEN_W-1:0]     out_slice_length;
  logic [COUNT_W-1:0]   out_pull_count;
  logic [COUNT_W-1:0]   out_ack_count;
  logic [COUNT_W-1:0]   out_loss_count;

  int fail_count;
  int pending;
  int checked;

  // idle percentages, read by the sender task and the receiver process
  int send_idle_pct = 0;
  int stall_pct = 0;
  logic hold_ask = 1'b0;

  int reqs_sent = 0;
  int sizes_used = 0;

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  slice_retransmit_scheduler dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_req_type      (in_req_type),
    .in_block_index   (in_block_index),
    .in_have_mask     (in_have_mask),
    .in_slice_number  (in_slice_number),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_accepted     (out_accepted),
    .out_issued_slice (out_issued_slice),
    .out_byte_offset  (out_byte_offset),
    .out_slice_length (out_slice_length),
    .out_pull_count   (out_pull_count),
    .out_ack_count    (out_ack_count),
    .out_loss_count   (out_loss_count)
  );

  slice_schedule_checker checker_i (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_req_type      (in_req_type),
    .in_block_index   (in_block_index),
    .in_have_mask     (in_have_mask),
    .in_slice_number  (in_slice_number),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_accepted     (out_accepted),
    .out_issued_slice (out_issued_slice),
    .out_byte_offset  (out_byte_offset),
    .out_slice_length (out_slice_length),
    .out_pull_count   (out_pull_count),
    .out_ack_count    (out_ack_count),
    .out_loss_count   (out_loss_count),
    .fail_count       (fail_count),
    .pending          (pending),
    .checked          (checked)
  );

  // receiver side: random stalls, plus one long hold on request so the
  // two pipeline registers fill and in_stall rises
  initial begin
    int hold_left;
    hold_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_ask) begin
        hold_ask = 1'b0;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // safety net against a hung handshake
  initial begin
    #2_000_000;
    $display("timeout: results still outstanding or input stuck");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic set_idling(input idle_mode_t mode);
    case (mode)
      IDLE_NONE: begin
        send_idle_pct = 0;
        stall_pct = 0;
      end
      IDLE_SENDER: begin
        send_idle_pct = 73;
        stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        send_idle_pct = 0;
        stall_pct = 73;
      end
      default: begin
        send_idle_pct = 35;
        stall_pct = 35;
      end
    endcase
  endtask

  // offer one request and return at the edge where it is taken; valid stays
  // high across back-to-back items and only drops for a sender gap
  task automatic send_item(input req_type_t kind, input logic [BLOCK_W-1:0] blk,
                           input logic [MASK_W-1:0] have, input logic [SLICE_W-1:0] sn);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_req_type     <= kind;
    in_block_index  <= blk;
    in_have_mask    <= have;
    in_slice_number <= sn;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    reqs_sent++;
  endtask

  // let every result drain before touching the register
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_file_size(input logic [FILE_W-1:0] size_bytes);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= size_bytes;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    sizes_used++;
  endtask

  function automatic logic [MASK_W-1:0] pick_have_mask();
    case ($urandom_range(3))
      0: return '0;
      1: return {$urandom, $urandom};
      2: return {$urandom, $urandom} | {$urandom, $urandom};
      default: return ~(64'd1 << $urandom_range(63));
    endcase
  endfunction

  initial begin
    logic [FILE_W-1:0]  fsize;
    logic [63:0]        nblk;
    logic [BLOCK_W-1:0] blk;
    logic [BLOCK_W-1:0] recent_block;
    logic [SLICE_W-1:0] sn;
    int phase_start;
    int burst;
    int pick;

    rst_n           <= 1'b0;
    cfg_wr_en       <= 1'b0;
    cfg_wr_data     <= '0;
    in_valid        <= 1'b0;
    in_req_type     <= REQ_BLOCK;
    in_block_index  <= '0;
    in_have_mask    <= '0;
    in_slice_number <= '0;
    recent_block = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // ---- directed part ----
    set_idling(IDLE_NONE);

    // empty file: every block is past the end, pulls find nothing
    write_file_size('0);
    send_item(REQ_BLOCK, '0, '0, '0);
    send_item(REQ_PULL, '0, '0, '0);
    send_item(REQ_ACK, '0, '0, '0);
    send_item(REQ_LOSS, '0, '0, 32'hFFFF_FFFF);

    // one full block plus a 100-byte tail block
    write_file_size(40'd65636);
    send_item(REQ_BLOCK, '0, '1, '0);                        // receiver has all: rejected
    send_item(REQ_BLOCK, '0, 64'hFFFF_FFFF_FFFF_FFFA, '0);  // slices 0 and 2 missing
    send_item(REQ_PULL, '0, '0, '0);
    send_item(REQ_LOSS, '0, '0, 32'd0);                     // slice 0 goes back
    send_item(REQ_ACK, '0, '0, 32'd2);                      // not awaiting, counted only
    // mask bit past the tail is ignored, old bits carry into block 1
    send_item(REQ_BLOCK, 32'd1, 64'hFFFF_FFFF_FFFF_FFDF, '0);
    send_item(REQ_PULL, '0, '0, '0);                        // short tail slice
    send_item(REQ_PULL, '0, '0, '0);                        // past end of file, zero length
    send_item(REQ_ACK, '0, '0, 32'd3);                      // under the base, dropped
    send_item(REQ_LOSS, '0, '0, 32'd66);
    send_item(REQ_BLOCK, 32'd2, '0, '0);
    send_item(REQ_BLOCK, 32'hFFFF_FFFF, '0, '0);
    send_item(REQ_PULL, '0, '0, '0);

    // largest file: last block and the widest offsets
    write_file_size('1);
    send_item(REQ_BLOCK, 32'h00FF_FFFF, '0, '0);
    send_item(REQ_PULL, '0, '0, '0);
    send_item(REQ_ACK, '0, '0, 32'hFFFF_FFFF);
    send_item(REQ_BLOCK, 32'h0100_0000, '0, '0);

    // one-byte file
    write_file_size(40'd1);
    send_item(REQ_BLOCK, '0, 64'hFFFF_FFFF_FFFF_FFFE, '0);
    send_item(REQ_PULL, '0, '0, '0);

    // ---- random part: bursts of block requests, pulls, acks and losses ----
    for (int p = 0; p < PHASES; p++) begin
      case (p % 5)
        0: fsize = 40'($urandom_range(1, 6 * 65536));
        1: fsize = '1;
        2: fsize = 40'($urandom_range(1, 12)) * 40'd65536;
        3: fsize = {8'($urandom_range(0, 255)), 32'($urandom)};
        default: fsize = (p == 4) ? '0 : 40'($urandom_range(1, 3000));
      endcase
      write_file_size(fsize);
      nblk = ({24'b0, fsize} + 64'd65535) >> 16;
      recent_block = '0;
      set_idling(idle_mode_t'(p % 4));
      // long output hold while the sender keeps going
      if (p == 0) hold_ask = 1'b1;
      phase_start = reqs_sent;
      while (reqs_sent - phase_start < PHASE_REQS) begin
        if ($urandom_range(99) < 12) begin
          // noise over the whole field ranges
          send_item(req_type_t'($urandom_range(3)), $urandom, {$urandom, $urandom}, $urandom);
        end else begin
          if (nblk != 0) begin
            pick = $urandom_range(9);
            if (pick == 0) blk = '0;
            else if (pick == 1) blk = 32'(nblk - 64'd1);
            else if (pick == 2) blk = 32'(nblk);          // one past the end
            else blk = $urandom_range(0, 32'(nblk - 64'd1));
            if (64'(blk) < nblk) recent_block = blk;
          end else begin
            blk = $urandom;
          end
          send_item(REQ_BLOCK, blk, pick_have_mask(), '0);
          burst = $urandom_range(1, 10);
          repeat (burst) begin
            pick = $urandom_range(9);
            sn = recent_block * 32'd64 + 32'($urandom_range(0, 63));
            case ($urandom_range(9))
              0: sn = sn + 32'($urandom_range(64, 200));    // above the block
              1: sn = sn - 32'($urandom_range(64, 200));    // under the base
              default: ;
            endcase
            if (pick < 5) send_item(REQ_PULL, '0, '0, sn);
            else if (pick < 8) send_item(REQ_ACK, '0, '0, sn);
            else send_item(REQ_LOSS, '0, '0, sn);
          end
        end
      end
    end

    // ---- wind down ----
    wait_drained();
    repeat (4) @(posedge clk);
    $display("Summary: %0d requests over %0d file sizes and four idle patterns,",
             reqs_sent, sizes_used);
    $display("         %0d results checked, including one long output hold", checked);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
